[rtl/rau_pkg.sv]
`default_nettype none
package rau_pkg;
  localparam int unsigned OpW = 32;
  localparam int unsigned WideW = 64;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_DIV = 2'd2,
    KIND_RED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_GCD0,
    S_DIVA,
    S_DIVB,
    S_ADDM1,
    S_ADDM2,
    S_ADDM3,
    S_ADDM4,
    S_GCDL,
    S_DIVQ,
    S_DIVL,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic top;
    logic [WideW-1:0] hi_lo;
    logic [WideW-1:0] dvsr;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic qtop;
    logic [WideW-1:0] quo;
    logic [WideW-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/rau_if.sv]
`default_nettype none
interface rau_in_if (input wire logic clk_i);
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [rau_pkg::OpW-1:0] a_num;
  logic [rau_pkg::OpW-1:0] a_den;
  logic [rau_pkg::OpW-1:0] b_num;
  logic [rau_pkg::OpW-1:0] b_den;
  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if (input wire logic clk_i);
  logic valid;
  logic ready;
  logic [rau_pkg::WideW-1:0] res_num;
  logic [rau_pkg::WideW-1:0] res_den;
  logic [1:0] status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

[rtl/rau_div.sv]
`default_nettype none
// 65-bit by 64-bit restoring divider, one quotient bit per cycle
module rau_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t      rsp_o
);
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [rau_pkg::WideW-1:0] r_q, r_d, q_q, q_d, d_q, d_d;
  logic top_q, top_d, qt_q, qt_d;
  logic [rau_pkg::WideW:0] sh;
  logic bit_in, ge;

  always_comb begin
    bit_in = (cnt_q == 7'd64) ? top_q : q_q[rau_pkg::WideW-1];
    sh = {r_q, bit_in};
    ge = sh[rau_pkg::WideW] || (sh[rau_pkg::WideW-1:0] >= d_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    r_d = r_q;
    q_d = q_q;
    d_d = d_q;
    top_d = top_q;
    qt_d = qt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd64;
      r_d = '0;
      q_d = req_i.hi_lo;
      d_d = req_i.dvsr;
      top_d = req_i.top;
      qt_d = 1'b0;
    end else if (busy_q) begin
      r_d = ge ? (sh[rau_pkg::WideW-1:0] - d_q) : sh[rau_pkg::WideW-1:0];
      if (cnt_q == 7'd64) begin
        qt_d = ge;
      end else begin
        q_d = {q_q[rau_pkg::WideW-2:0], ge};
      end
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_d;
    top_q <= top_d;
    qt_q <= qt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.qtop = qt_q;
  assign rsp_o.quo = q_q;
  assign rsp_o.rem = r_q;
endmodule
`default_nettype wire

[rtl/rational_arith_unit.sv]
`default_nettype none
// Rational arithmetic unit: add, multiply, divide or reduce unsigned fractions.
// Input channel in (kind, a_num, a_den, b_num, b_den): one word is taken while
// the unit is idle; in.ready stays low until the result word has left.
// Output channel out (res_num, res_den, status): one word per input word,
// reduced to lowest terms, or zeros with a nonzero status.
// All divisions, each Euclid step of a GCD among them, run through one
// shared restoring divider. A zero denominator or a division by zero goes
// straight to out with zeros and status ST_ZERO. A GCD takes up to about 47
// steps on 32-bit and 93 on 64-bit values.
// Multiplies use one 32x32 product per cycle.
// Reset returns the sequencer to idle with out.valid low.
// A finished word holds on out until out.ready; the next input word is taken
// from the cycle after the result leaves.
module rational_arith_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  rau_in_if.sink   in,
  rau_out_if.source out
);
  localparam int unsigned W = rau_pkg::WideW;

  rau_pkg::state_e st_q, st_d;
  rau_pkg::state_e ret_q, ret_d;
  logic gbusy_q, gbusy_d;
  logic [1:0] kind_q, kind_d;
  logic [rau_pkg::OpW-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [rau_pkg::OpW-1:0] ag_q, ag_d;
  logic [W-1:0] x_q, x_d, y_q, y_d;
  logic [W-1:0] n_q, n_d, d_q, d_d, g_q, g_d;
  logic [W-1:0] t1_q, t1_d;
  logic [W-1:0] on_q, on_d, od_q, od_d;
  logic [1:0] os_q, os_d;
  logic hi_q, hi_d;
  logic ov_q, ov_d;
  logic [rau_pkg::OpW-1:0] ma, mb;
  logic [W-1:0] prod;
  logic [W:0] sum;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;

  rau_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign prod = W'(ma) * W'(mb);
  assign sum = {1'b0, t1_q} + {1'b0, prod};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      rau_pkg::S_IDLE: begin
        if (in.valid) begin
          if (in.a_den == '0) begin
            st_d = rau_pkg::S_OUT;
          end else if (in.kind == rau_pkg::KIND_RED) begin
            st_d = rau_pkg::S_GCD0;
          end else if (in.b_den == '0 ||
                       (in.kind == rau_pkg::KIND_DIV && in.b_num == '0)) begin
            st_d = rau_pkg::S_OUT;
          end else if (in.kind == rau_pkg::KIND_ADD) begin
            st_d = rau_pkg::S_GCD0;
          end else begin
            st_d = rau_pkg::S_MUL1;
          end
        end
      end
      rau_pkg::S_MUL1: st_d = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: st_d = rau_pkg::S_GCD0;
      rau_pkg::S_GCD0: st_d = (y_q == '0) ? ret_q : rau_pkg::S_GCD0;
      rau_pkg::S_DIVA: if (drsp.done) st_d = rau_pkg::S_DIVB;
      rau_pkg::S_DIVB: if (drsp.done) st_d = rau_pkg::S_OUT;
      rau_pkg::S_ADDM1: if (drsp.done) st_d = rau_pkg::S_ADDM2;
      rau_pkg::S_ADDM2: if (drsp.done) st_d = rau_pkg::S_ADDM3;
      rau_pkg::S_ADDM3: st_d = rau_pkg::S_ADDM4;
      rau_pkg::S_ADDM4: st_d = rau_pkg::S_DIVQ;
      rau_pkg::S_DIVQ: if (drsp.done) st_d = rau_pkg::S_GCD0;
      rau_pkg::S_GCDL: if (drsp.done) st_d = rau_pkg::S_DIVL;
      rau_pkg::S_DIVL: if (drsp.done) st_d = rau_pkg::S_OUT;
      rau_pkg::S_OUT: if (out.ready) st_d = rau_pkg::S_IDLE;
      default: st_d = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_d = kind_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    ag_d = ag_q;
    x_d = x_q; y_d = y_q; n_d = n_q; d_d = d_q; g_d = g_q;
    t1_d = t1_q; hi_d = hi_q; ov_d = ov_q;
    on_d = on_q; od_d = od_q; os_d = os_q;
    ret_d = ret_q;
    gbusy_d = gbusy_q;
    dreq = '0;
    ma = an_q;
    mb = bn_q;
    in.ready = (st_q == rau_pkg::S_IDLE);
    out.valid = (st_q == rau_pkg::S_OUT);
    unique case (st_q)
      rau_pkg::S_IDLE: begin
        kind_d = in.kind;
        an_d = in.a_num; ad_d = in.a_den; bn_d = in.b_num; bd_d = in.b_den;
        on_d = '0; od_d = '0; os_d = rau_pkg::ST_ZERO;
        gbusy_d = 1'b0;
        hi_d = 1'b0; ov_d = 1'b0;
        n_d = W'(in.a_num); d_d = W'(in.a_den);
        if (in.kind == rau_pkg::KIND_ADD) begin
          x_d = W'(in.a_den); y_d = W'(in.b_den); ret_d = rau_pkg::S_ADDM1;
        end else begin
          x_d = W'(in.a_num); y_d = W'(in.a_den); ret_d = rau_pkg::S_DIVA;
        end
      end
      rau_pkg::S_MUL1: begin
        ma = an_q;
        mb = (kind_q == rau_pkg::KIND_MUL) ? bn_q : bd_q;
        n_d = prod; x_d = prod;
      end
      rau_pkg::S_MUL2: begin
        ma = ad_q;
        mb = (kind_q == rau_pkg::KIND_MUL) ? bd_q : bn_q;
        d_d = prod; y_d = prod;
      end
      rau_pkg::S_GCD0: begin
        if (y_q == '0) begin
          g_d = x_q;
          gbusy_d = 1'b0;
          if (ret_q == rau_pkg::S_DIVA) begin
            dreq.start = 1'b1; dreq.hi_lo = n_q; dreq.dvsr = x_q;
          end else if (ret_q == rau_pkg::S_ADDM1) begin
            dreq.start = 1'b1; dreq.hi_lo = W'(ad_q); dreq.dvsr = x_q;
          end else begin
            dreq.start = 1'b1; dreq.top = hi_q; dreq.hi_lo = n_q; dreq.dvsr = x_q;
          end
        end else if (!gbusy_q) begin
          dreq.start = 1'b1; dreq.hi_lo = x_q; dreq.dvsr = y_q;
          gbusy_d = 1'b1;
        end else if (drsp.done) begin
          x_d = y_q; y_d = drsp.rem; gbusy_d = 1'b0;
        end
      end
      rau_pkg::S_DIVA: begin
        if (drsp.done) begin
          on_d = drsp.quo;
          dreq.start = 1'b1; dreq.hi_lo = d_q; dreq.dvsr = g_q;
        end
      end
      rau_pkg::S_DIVB: begin
        if (drsp.done) begin
          od_d = drsp.quo; os_d = rau_pkg::ST_OK;
        end
      end
      rau_pkg::S_ADDM1: begin
        // ad/g ready; start bd/g
        if (drsp.done) begin
          ag_d = drsp.quo[rau_pkg::OpW-1:0];
          dreq.start = 1'b1; dreq.hi_lo = W'(bd_q); dreq.dvsr = g_q;
        end
      end
      rau_pkg::S_ADDM2: begin
        // t1 = an*(bd/g)
        if (drsp.done) begin
          ma = an_q; mb = drsp.quo[rau_pkg::OpW-1:0];
          t1_d = prod;
        end
      end
      rau_pkg::S_ADDM3: begin
        // t2 = bn*(ad/g), 65-bit sum
        ma = bn_q; mb = ag_q;
        n_d = sum[W-1:0]; hi_d = sum[W];
      end
      rau_pkg::S_ADDM4: begin
        // l = (ad/g)*bd; remainder of (hi:n)/l
        ma = ag_q; mb = bd_q;
        d_d = prod;
        dreq.start = 1'b1; dreq.top = hi_q; dreq.hi_lo = n_q; dreq.dvsr = prod;
      end
      rau_pkg::S_DIVQ: begin
        if (drsp.done) begin
          x_d = d_q; y_d = drsp.rem; ret_d = rau_pkg::S_GCDL;
        end
      end
      rau_pkg::S_GCDL: begin
        if (drsp.done) begin
          on_d = drsp.quo; ov_d = drsp.qtop;
          dreq.start = 1'b1; dreq.hi_lo = d_q; dreq.dvsr = g_q;
        end
      end
      rau_pkg::S_DIVL: begin
        if (drsp.done) begin
          if (ov_q) begin
            on_d = '0; od_d = '0; os_d = rau_pkg::ST_OVF;
          end else begin
            od_d = drsp.quo; os_d = rau_pkg::ST_OK;
          end
        end
      end
      rau_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rau_pkg::S_IDLE;
      ret_q <= rau_pkg::S_IDLE;
      gbusy_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ret_q <= ret_d;
      gbusy_q <= gbusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    ag_q <= ag_d;
    x_q <= x_d; y_q <= y_d; n_q <= n_d; d_q <= d_d; g_q <= g_d;
    t1_q <= t1_d; hi_q <= hi_d; ov_q <= ov_d;
    on_q <= on_d; od_q <= od_d; os_q <= os_d;
  end

  assign out.res_num = on_q;
  assign out.res_den = od_q;
  assign out.status = os_q;
endmodule
`default_nettype wire

[rtl/rau_checker.sv]
`default_nettype none
module rau_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] status
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("in and out active together");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind rational_arith_unit rau_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .status(out.status)
);
`default_nettype wire
